@@ hw/rtl/line_rasterizer_defines.svh @@
// assertion macros for the line rasterizer checker
// no dependencies; included by lr_checker.sv, which carries the concurrent assertions
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define LR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/lr_pkg.sv @@
// types and constants for the line rasterizer
// no dependencies; imported by every rasterizer module
`default_nettype none

package lr_pkg;

    localparam int COORD_W = 6;
    localparam int COLOR_W = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [COORD_W-1:0] t_coord;

    // one line command word
    typedef struct packed {
        t_coord               x_start;
        t_coord               y_start;
        t_coord               x_end;
        t_coord               y_end;
        logic [COLOR_W-1:0]   line_color;
    } t_line_cmd;

    // one pixel word
    typedef struct packed {
        t_coord               pixel_x;
        t_coord               pixel_y;
        logic [COLOR_W-1:0]   pixel_color;
        logic                 last_pixel;
    } t_pixel;

    // classified line, major/minor form, ready for the walk
    typedef struct packed {
        t_coord               m0;
        t_coord               n0;
        t_coord               m1;
        t_coord               dmaj;
        t_coord               dmin;
        logic                 step_neg;
        logic                 steep;
        logic [COLOR_W-1:0]   color;
    } t_line_job;

endpackage

`default_nettype wire

@@ hw/rtl/lr_front.sv @@
// front end: clamps endpoints and sorts a line into major/minor form
// depends on lr_pkg
`default_nettype none

module lr_front #(
    parameter int TILE_SIZE = 64
) (
    input  lr_pkg::t_line_cmd i_cmd,
    output lr_pkg::t_line_job o_job
);
    import lr_pkg::*;

    localparam t_coord MAX_COORD = COORD_W'(TILE_SIZE - 1);

    function automatic t_coord clamp(input t_coord v);
        return (v > MAX_COORD) ? MAX_COORD : v;
    endfunction

    t_coord xa, ya, xb, yb;
    t_coord adx, ady;
    t_coord ma, na, mb, nb;
    t_coord m0, n0, m1, n1;
    logic   steep, swap;

    // clamp and classify
    always_comb begin
        xa = clamp(i_cmd.x_start);
        ya = clamp(i_cmd.y_start);
        xb = clamp(i_cmd.x_end);
        yb = clamp(i_cmd.y_end);
        adx = (xa > xb) ? xa - xb : xb - xa;
        ady = (ya > yb) ? ya - yb : yb - ya;
        steep = adx < ady;
        ma = steep ? ya : xa;
        na = steep ? xa : ya;
        mb = steep ? yb : xb;
        nb = steep ? xb : yb;
        // walk always starts from the smaller major coordinate
        swap = ma > mb;
        m0 = swap ? mb : ma;
        n0 = swap ? nb : na;
        m1 = swap ? ma : mb;
        n1 = swap ? na : nb;
        o_job.m0 = m0;
        o_job.n0 = n0;
        o_job.m1 = m1;
        o_job.dmaj = m1 - m0;
        o_job.dmin = (n1 > n0) ? n1 - n0 : n0 - n1;
        o_job.step_neg = !(n1 > n0);
        o_job.steep = steep;
        o_job.color = i_cmd.line_color;
    end

endmodule

`default_nettype wire

@@ hw/rtl/lr_queue.sv @@
// short job queue between the front end and the walker
// depends on lr_pkg
`default_nettype none

module lr_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  lr_pkg::t_line_job i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output lr_pkg::t_line_job o_data
);
    import lr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_line_job          r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lr_walker.sv @@
// back end: walks the major axis one pixel per cycle while the output is not stalled, with the error term
// depends on lr_pkg
`default_nettype none

module lr_walker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_job_empty,
    input  lr_pkg::t_line_job i_job,
    output logic              o_job_pop,
    output logic              o_out_valid,
    output lr_pkg::t_pixel    o_out_word,
    input  wire               i_out_stall
);
    import lr_pkg::*;

    typedef enum logic {ST_IDLE, ST_WALK} t_walk_state;

    t_walk_state        r_state;
    t_coord             r_m, r_n, r_m1, r_dmaj, r_dmin;
    logic               r_step_neg, r_steep;
    logic [COLOR_W-1:0] r_color;
    logic signed [7:0]  r_err;

    logic               out_free, emit, is_last, do_step;
    logic signed [7:0]  n_err_sum;
    logic signed [8:0]  twice_err;
    t_coord             n_n;

    assign out_free  = !o_out_valid || !i_out_stall;
    assign emit      = (r_state == ST_WALK) && out_free;
    assign o_job_pop = (r_state == ST_IDLE) && !i_job_empty;
    assign is_last   = (r_m == r_m1);

    // error update for the next pixel
    always_comb begin
        n_err_sum = r_err + $signed({2'b00, r_dmin});
        twice_err = {n_err_sum, 1'b0};
        do_step   = twice_err > $signed({3'b000, r_dmaj});
        n_n       = do_step ? (r_step_neg ? r_n - 1'b1 : r_n + 1'b1) : r_n;
    end

    // state, walk registers and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall && !emit) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_job_pop) begin
                        r_m        <= i_job.m0;
                        r_n        <= i_job.n0;
                        r_m1       <= i_job.m1;
                        r_dmaj     <= i_job.dmaj;
                        r_dmin     <= i_job.dmin;
                        r_step_neg <= i_job.step_neg;
                        r_steep    <= i_job.steep;
                        r_color    <= i_job.color;
                        r_err      <= '0;
                        r_state    <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (emit) begin
                        o_out_valid             <= 1'b1;
                        o_out_word.pixel_x      <= r_steep ? r_n : r_m;
                        o_out_word.pixel_y      <= r_steep ? r_m : r_n;
                        o_out_word.pixel_color  <= r_color;
                        o_out_word.last_pixel   <= is_last;
                        r_m   <= r_m + 1'b1;
                        r_n   <= n_n;
                        r_err <= do_step ? n_err_sum - $signed({2'b00, r_dmaj}) : n_err_sum;
                        if (is_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/line_rasterizer.sv @@
// Line rasterizer for one tile. A line command word is clamped and sorted
// into major/minor form as it is accepted, then waits in a two-entry queue,
// so up to two further commands are taken while a line is drawn. The walker
// emits one pixel word per cycle while the output is not stalled: a line of
// major-axis length L gives L+1 pixel words (1 to 64), and the walker loads
// the next command from the queue in its idle state between lines. Pixels
// appear in walk order, the final one flagged.
// top level; depends on lr_pkg, lr_front, lr_queue, lr_walker
`default_nettype none

module line_rasterizer #(
    parameter int TILE_SIZE = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  lr_pkg::t_line_cmd i_in_word,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output lr_pkg::t_pixel    o_out_word,
    input  wire               i_out_stall
);
    import lr_pkg::*;

    t_line_job front_job, head_job;
    logic      q_full, q_empty, q_pop;

    assign o_in_stall = q_full;

    // classify incoming commands
    lr_front #(
        .TILE_SIZE(TILE_SIZE)
    ) u_front (
        .i_cmd (i_in_word),
        .o_job (front_job)
    );

    // decouple front and back
    lr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (head_job)
    );

    // pixel walk
    lr_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (head_job),
        .o_job_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lr_checker.sv @@
// port-level checks for the line rasterizer, bound to the top level
// depends on lr_pkg and line_rasterizer_defines.svh
`default_nettype none
`include "line_rasterizer_defines.svh"

module lr_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            o_out_valid,
    input lr_pkg::t_pixel o_out_word,
    input wire            i_out_stall
);
    import lr_pkg::*;

    logic   mid_line_take, out_wait, word_held, step_ok, valid_known;
    t_pixel r_prev_word;

    assign mid_line_take = o_out_valid && !i_out_stall && !o_out_word.last_pixel;
    assign out_wait      = o_out_valid && i_out_stall;
    assign valid_known   = !$isunknown(o_out_valid);

    // pixel word seen at the previous edge
    always_ff @(posedge i_clk) begin
        r_prev_word <= o_out_word;
    end

    assign word_held = o_out_valid && (o_out_word == r_prev_word);
    assign step_ok   = (o_out_word.pixel_color == r_prev_word.pixel_color) &&
                       ((o_out_word.pixel_x == r_prev_word.pixel_x) ||
                        (o_out_word.pixel_x == r_prev_word.pixel_x + 6'd1) ||
                        (o_out_word.pixel_x == r_prev_word.pixel_x - 6'd1));

    // a stalled pixel word holds
    `LR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, word_held, "stalled word changed")

    // inside a line the next pixel follows straight away
    `LR_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, mid_line_take, o_out_valid, "gap inside a line")

    // neighbouring pixels of a line share the colour and differ in x by at most one
    `LR_ASSERT_NEXT(a_adjacent, i_clk, i_rst_n, mid_line_take, step_ok, "pixels not adjacent")

    // output valid is always a known level out of reset
    `LR_ASSERT_IMP(a_valid_known, i_clk, i_rst_n, 1'b1, valid_known, "output valid unknown")

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);

`default_nettype wire
